FILE: hdl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and widths for the chunk reception bitmap.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 16;
	localparam int CNT_W      = 11;
	localparam int LIM_W      = 7;
	localparam int MIDX_W     = 10;
	localparam int ROW_W      = 32;
	localparam int BIT_W      = 5;
	localparam int QDEPTH     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam int MAP_BITS_DEF = 1024;
	localparam int MAX_LIST_DEF = 64;

	localparam logic [LIM_W-1:0] MAXMISS_RESET = 7'd16;

	localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAXMISS = 1'd1;

	// classified request, front to back
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              in_range;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	// one result
	typedef struct packed {
		logic              is_new;
		logic              in_range;
		logic [CNT_W-1:0]  count;
		logic              all_rcv;
		logic [MIDX_W-1:0] midx;
		logic              mvalid;
		logic              last;
	} res_t;

endpackage

FILE: hdl/cbm_ram.sv
// ----------------------------------------------------------------------------
// cbm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/cbm_front.sv
// ----------------------------------------------------------------------------
// cbm_front
// Request intake: handshake and range check of arriving chunk indices.
// ----------------------------------------------------------------------------
module cbm_front (
	input  logic                        start,
	input  logic [cbm_pkg::FUNC_W-1:0]  func,
	input  logic [cbm_pkg::IDX_W-1:0]   chunk_id,
	input  logic [cbm_pkg::CNT_W-1:0]   eff_total,
	input  logic                        q_full,
	input  logic                        initializing,
	output logic                        busy,
	output logic                        push,
	output cbm_pkg::cmd_t               cmd
);
	import cbm_pkg::*;

	assign busy = q_full | initializing;
	assign push = start & ~busy;

	always_comb begin
		cmd.func     = func;
		cmd.idx      = chunk_id;
		// chunk must sit below the saturated session total
		cmd.in_range = (32'(chunk_id) < 32'(eff_total));
	end

endmodule

FILE: hdl/cbm_queue.sv
// ----------------------------------------------------------------------------
// cbm_queue
// Short FIFO of classified requests between intake and execution.
// ----------------------------------------------------------------------------
module cbm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cbm_pkg::cmd_t cmd_in,
	input  logic          pop,
	output cbm_pkg::cmd_t cmd_out,
	output logic          empty,
	output logic          full
);
	import cbm_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == CW'(QDEPTH));
	assign cmd_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: hdl/cbm_back.sv
// ----------------------------------------------------------------------------
// cbm_back
// Request execution: bitmap clear, arrival read-modify-write, missing scan.
// ----------------------------------------------------------------------------
module cbm_back #(
	parameter int MAP_BITS = cbm_pkg::MAP_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cbm_pkg::CNT_W-1:0]  eff_total,
	input  logic [cbm_pkg::LIM_W-1:0]  eff_limit,
	input  cbm_pkg::cmd_t              cmd,
	input  logic                       q_empty,
	output logic                       pop,
	output logic                       initializing,
	output logic                       stb,
	output cbm_pkg::res_t              res
);
	import cbm_pkg::*;

	localparam int ROWS = (MAP_BITS + ROW_W - 1) / ROW_W;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int XW   = RAW + BIT_W;
	localparam int PTRW = XW + 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ARCHK = 3'd2;
	localparam logic [2:0] S_SCRD  = 3'd3;
	localparam logic [2:0] S_SCBIT = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [2:0]       state_q;
	logic [RAW-1:0]   rc_q;
	logic             report_q;
	logic [CNT_W-1:0] count_q;
	logic [PTRW-1:0]  ptr_q;
	logic [LIM_W-1:0] found_q;
	logic             pend_v_q;
	logic [XW-1:0]    pend_idx_q;
	logic [XW-1:0]    idx_q;
	logic             stb_q;
	res_t             res_q;

	logic             rd_en, wr_en;
	logic [RAW-1:0]   rd_addr, wr_addr;
	logic [ROW_W-1:0] wr_data, rd_data;
	logic             bit_set, scan_bit, scan_end;

	function automatic res_t mk_res(input logic is_new, input logic in_range,
			input logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] tot,
			input logic [MIDX_W-1:0] midx, input logic mvalid, input logic last);
		res_t r;
		r.is_new   = is_new;
		r.in_range = in_range;
		r.count    = cnt;
		r.all_rcv  = (cnt >= tot);
		r.midx     = midx;
		r.mvalid   = mvalid;
		r.last     = last;
		return r;
	endfunction

	cbm_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign pop          = (state_q == S_IDLE) & ~q_empty;
	assign initializing = (state_q == S_CLEAR) & ~report_q;
	assign bit_set      = rd_data[idx_q[BIT_W-1:0]];
	assign scan_bit     = rd_data[ptr_q[BIT_W-1:0]];
	assign scan_end     = (32'(ptr_q) >= 32'(eff_total)) | (found_q == eff_limit);
	assign stb          = stb_q;
	assign res          = res_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = rc_q;
		wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				rd_en   = ~q_empty & (cmd.func == FUNC_ARRIVE) & cmd.in_range;
				rd_addr = cmd.idx[XW-1:BIT_W];
			end
			S_ARCHK: begin
				wr_en   = ~bit_set;
				wr_addr = idx_q[XW-1:BIT_W];
				wr_data = rd_data | (ROW_W'(1) << idx_q[BIT_W-1:0]);
			end
			S_SCRD: begin
				rd_en   = 1'b1;
				rd_addr = ptr_q[XW-1:BIT_W];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_CLEAR: begin
				res_q <= mk_res(1'b0, 1'b0, '0, eff_total, '0, 1'b0, 1'b1);
			end
			S_IDLE: begin
				res_q <= mk_res(1'b0, 1'b0, count_q, eff_total, '0, 1'b0, 1'b1);
			end
			S_ARCHK: begin
				if (!bit_set) begin
					res_q <= mk_res(1'b1, 1'b1, count_q + 1'b1, eff_total, '0, 1'b0, 1'b1);
				end else begin
					res_q <= mk_res(1'b0, 1'b1, count_q, eff_total, '0, 1'b0, 1'b1);
				end
			end
			S_SCBIT: begin
				res_q <= mk_res(1'b0, 1'b0, count_q, eff_total, MIDX_W'(pend_idx_q),
					1'b1, 1'b0);
			end
			S_FLUSH: begin
				res_q <= mk_res(1'b0, 1'b0, count_q, eff_total,
					pend_v_q ? MIDX_W'(pend_idx_q) : '0, pend_v_q, 1'b1);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop) begin
			idx_q <= cmd.idx[XW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			rc_q       <= '0;
			report_q   <= 1'b0;
			count_q    <= '0;
			ptr_q      <= '0;
			found_q    <= '0;
			pend_v_q   <= 1'b0;
			pend_idx_q <= '0;
			stb_q      <= 1'b0;
		end else begin
			stb_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					rc_q <= rc_q + 1'b1;
					if (rc_q == RAW'(ROWS - 1)) begin
						count_q <= '0;
						stb_q   <= report_q;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						case (cmd.func)
							FUNC_START: begin
								rc_q     <= '0;
								report_q <= 1'b1;
								state_q  <= S_CLEAR;
							end
							FUNC_ARRIVE: begin
								if (cmd.in_range) begin
									state_q <= S_ARCHK;
								end else begin
									stb_q <= 1'b1;
								end
							end
							FUNC_LIST: begin
								ptr_q    <= '0;
								found_q  <= '0;
								pend_v_q <= 1'b0;
								state_q  <= S_SCRD;
							end
							default: begin
								stb_q <= 1'b1;
							end
						endcase
					end
				end
				S_ARCHK: begin
					if (!bit_set) begin
						count_q <= count_q + 1'b1;
					end
					stb_q   <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCRD: begin
					state_q <= S_SCBIT;
				end
				S_SCBIT: begin
					if (scan_end) begin
						state_q <= S_FLUSH;
					end else begin
						// hold one find back so the final one can carry last
						if (!scan_bit) begin
							stb_q      <= pend_v_q;
							pend_v_q   <= 1'b1;
							pend_idx_q <= ptr_q[XW-1:0];
							found_q    <= found_q + 1'b1;
						end
						ptr_q <= ptr_q + 1'b1;
						if (ptr_q[BIT_W-1:0] == '1) begin
							state_q <= S_SCRD;
						end
					end
				end
				S_FLUSH: begin
					stb_q   <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// no result may leave during the power-up clear
	a_no_res_init: assert property (@(posedge clk) disable iff (!arst_n)
		initializing |-> !stb_q)
		else $error("result during initial clear");

	// map port is read or written, never both in one cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("bitmap read and write collide");

	// scan never finds more than the list limit
	a_found_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCBIT) |-> (found_q <= eff_limit))
		else $error("missing list exceeds limit");

	// a missing-list entry that is not last is followed by more scanning
	a_list_more: assert property (@(posedge clk) disable iff (!arst_n)
		(stb_q && res_q.mvalid && !res_q.last) |-> (state_q == S_SCBIT ||
			state_q == S_SCRD || state_q == S_FLUSH))
		else $error("open missing list abandoned");

endmodule

FILE: hdl/chunk_reception_bitmap.sv
// ----------------------------------------------------------------------------
// chunk_reception_bitmap
// Receive-side chunk bookkeeping: one bit per chunk, distinct-chunk count,
// session start, arrival check and ascending missing-chunk listing.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low; every
// result shows for exactly one cycle with done high and must be captured
// then, since the block cannot be held off. Requests go into a two-entry
// queue, so a couple can be posted while the engine works. The bitmap sits in
// a RAM of 32-bit rows (MAP_BITS/32 rows, rounded up) and every request
// is served through that RAM, one at a time: an arrival reads its row,
// then tests the bit and writes the row back; a session start clears one
// row a cycle; an unknown func answers without touching the map; a missing
// list walks one bit a cycle, with an extra row read before each row, and
// stops at the session total or just past the last listed chunk. After
// reset the same row clear runs once with busy high and no result; config
// writes are taken at any time. Configuration is expected to change only
// with no request in flight.
// ----------------------------------------------------------------------------
module chunk_reception_bitmap #(
	parameter int MAP_BITS = cbm_pkg::MAP_BITS_DEF,
	parameter int MAX_LIST = cbm_pkg::MAX_LIST_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request
	input  logic                            start,
	output logic                            busy,
	input  logic [cbm_pkg::FUNC_W-1:0]      func,
	input  logic [cbm_pkg::IDX_W-1:0]       chunk_id,
	// result
	output logic                            done,
	output logic                            chunk_is_new,
	output logic                            chunk_in_range,
	output logic [cbm_pkg::CNT_W-1:0]       received_count,
	output logic                            all_received,
	output logic [cbm_pkg::MIDX_W-1:0]      missing_index,
	output logic                            missing_valid,
	output logic                            last,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cbm_pkg::*;

	logic [CNT_W-1:0] total_q;
	logic [LIM_W-1:0] maxmiss_q;
	logic [CNT_W-1:0] eff_total;
	logic [LIM_W-1:0] eff_limit;

	cmd_t push_cmd, head_cmd;
	logic push, pop, q_empty, q_full, initializing;
	res_t res;

	// registers are always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			maxmiss_q <= MAXMISS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOTAL:   total_q   <= cfg_data;
				REG_MAXMISS: maxmiss_q <= cfg_data[LIM_W-1:0];
				default:     total_q   <= total_q;
			endcase
		end
	end

	// session total saturates at the bitmap size
	assign eff_total = (32'(total_q) > MAP_BITS) ? CNT_W'(MAP_BITS) : total_q;

	// list limit forced into 1..MAX_LIST, zero reads as one
	always_comb begin
		if (maxmiss_q == '0) begin
			eff_limit = LIM_W'(1);
		end else if (32'(maxmiss_q) > MAX_LIST) begin
			eff_limit = LIM_W'(MAX_LIST);
		end else begin
			eff_limit = maxmiss_q;
		end
	end

	cbm_front u_front (
		.start        (start),
		.func         (func),
		.chunk_id     (chunk_id),
		.eff_total    (eff_total),
		.q_full       (q_full),
		.initializing (initializing),
		.busy         (busy),
		.push         (push),
		.cmd          (push_cmd)
	);

	cbm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (push_cmd),
		.pop     (pop),
		.cmd_out (head_cmd),
		.empty   (q_empty),
		.full    (q_full)
	);

	cbm_back #(.MAP_BITS(MAP_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.eff_total    (eff_total),
		.eff_limit    (eff_limit),
		.cmd          (head_cmd),
		.q_empty      (q_empty),
		.pop          (pop),
		.initializing (initializing),
		.stb          (done),
		.res          (res)
	);

	assign chunk_is_new   = res.is_new;
	assign chunk_in_range = res.in_range;
	assign received_count = res.count;
	assign all_received   = res.all_rcv;
	assign missing_index  = res.midx;
	assign missing_valid  = res.mvalid;
	assign last           = res.last;

endmodule
